>>> rtl/core/mime_encoded_word_base64_core_macros.svh
// assertion macros for the encoded word encoder checker
`ifndef MIME_ENCODED_WORD_BASE64_CORE_MACROS_SVH
`define MIME_ENCODED_WORD_BASE64_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define MEWB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mewb check failed");

// next-cycle implication, disabled in reset
`define MEWB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mewb check failed");

`endif

>>> rtl/core/mewb_pkg.sv
// shared types, constants and character functions of the encoded word encoder
`timescale 1ns / 1ps

package mewb_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CharW   = 7;
  localparam int unsigned SextW   = 6;
  localparam int unsigned PfxIdxW = 4;

  localparam logic [PfxIdxW-1:0] PfxLastIdx = 4'd15;

  localparam logic [CharW-1:0] ChEq = 7'h3D;
  localparam logic [CharW-1:0] ChQm = 7'h3F;

  localparam logic [SextW-1:0] SextUpperMax = 6'h19;
  localparam logic [SextW-1:0] SextLowerMax = 6'h33;
  localparam logic [SextW-1:0] SextDigitMax = 6'h3D;
  localparam logic [SextW-1:0] SextPlus     = 6'h3E;

  // one classified item: what the back end has to emit
  typedef struct packed {
    logic             prefix;
    logic             c0_vld;
    logic [SextW-1:0] s0;
    logic             c1_vld;
    logic [SextW-1:0] s1;
    logic [1:0]       pad;
    logic             term;
  } job_t;

  function automatic logic [CharW-1:0] sextet_char(input logic [SextW-1:0] v);
    logic [CharW-1:0] vv;
    vv = {1'b0, v};
    if (v <= SextUpperMax) begin
      return 7'h41 + vv;
    end else if (v <= SextLowerMax) begin
      return 7'h47 + vv;
    end else if (v <= SextDigitMax) begin
      return vv - 7'd4;
    end else if (v == SextPlus) begin
      return 7'h2B;
    end
    return 7'h2F;
  endfunction

  // "=?ISO-2022-JP?B?"
  function automatic logic [CharW-1:0] prefix_char(input logic [PfxIdxW-1:0] idx);
    logic [CharW-1:0] ch;
    case (idx)
      4'd0:    ch = 7'h3D;
      4'd1:    ch = 7'h3F;
      4'd2:    ch = 7'h49;
      4'd3:    ch = 7'h53;
      4'd4:    ch = 7'h4F;
      4'd5:    ch = 7'h2D;
      4'd6:    ch = 7'h32;
      4'd7:    ch = 7'h30;
      4'd8:    ch = 7'h32;
      4'd9:    ch = 7'h32;
      4'd10:   ch = 7'h2D;
      4'd11:   ch = 7'h4A;
      4'd12:   ch = 7'h50;
      4'd13:   ch = 7'h3F;
      4'd14:   ch = 7'h42;
      default: ch = 7'h3F;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/mewb_if.sv
// valid/ready channel interfaces for source beats and encoded characters
`timescale 1ns / 1ps

interface mewb_in_if;
  import mewb_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             terminator;

  modport source (output valid, output data_byte, output terminator, input ready);
  modport sink   (input valid, input data_byte, input terminator, output ready);
endinterface

interface mewb_out_if;
  import mewb_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] out_char;
  logic             last_of_run;
  logic             word_done;

  modport source (output valid, output out_char, output last_of_run, output word_done,
                  input ready);
  modport sink   (input valid, input out_char, input last_of_run, input word_done,
                  output ready);
endinterface

>>> rtl/core/mewb_front.sv
// front end: takes source beats, tracks group phase and leftover bits, builds jobs
`timescale 1ns / 1ps

module mewb_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mewb_in_if.sink               in_i,
  input  logic                  full_i,
  output logic                  push_o,
  output mewb_pkg::job_t        job_o
);
  import mewb_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       pfx_q, pfx_d;
  logic [1:0] phase;
  logic [ByteW-1:0] b;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign b          = in_i.data_byte;
  // phase three never occurs, fold it onto zero
  assign phase      = (phase_q == 2'd3) ? 2'd0 : phase_q;

  always_comb begin
    job_o        = '0;
    job_o.prefix = !pfx_q;
    phase_d      = phase;
    left_d       = left_q;
    pfx_d        = 1'b1;
    if (in_i.terminator) begin
      job_o.term = 1'b1;
      phase_d    = 2'd0;
      left_d     = 4'd0;
      pfx_d      = 1'b0;
      case (phase)
        2'd1: begin
          job_o.c0_vld = 1'b1;
          job_o.s0     = {left_q[1:0], 4'b0000};
          job_o.pad    = 2'd2;
        end
        2'd2: begin
          job_o.c0_vld = 1'b1;
          job_o.s0     = {left_q, 2'b00};
          job_o.pad    = 2'd1;
        end
        default: begin
          job_o.pad = 2'd0;
        end
      endcase
    end else begin
      job_o.c0_vld = 1'b1;
      case (phase)
        2'd1: begin
          job_o.s0 = {left_q[1:0], b[7:4]};
          left_d   = b[3:0];
          phase_d  = 2'd2;
        end
        2'd2: begin
          job_o.s0     = {left_q, b[7:6]};
          job_o.c1_vld = 1'b1;
          job_o.s1     = b[5:0];
          left_d       = 4'd0;
          phase_d      = 2'd0;
        end
        default: begin
          job_o.s0 = b[7:2];
          left_d   = {2'b00, b[1:0]};
          phase_d  = 2'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      left_q  <= 4'd0;
      pfx_q   <= 1'b0;
    end else if (push_o) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      pfx_q   <= pfx_d;
    end
  end

endmodule

>>> rtl/core/mewb_fifo.sv
// small register queue of jobs between front and back end
`timescale 1ns / 1ps

module mewb_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mewb_pkg::job_t wdata_i,
  input  logic           pop_i,
  output mewb_pkg::job_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);
  import mewb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/mewb_back.sv
// back end: walks each job one character per cycle into the output register while the output is not stalled
`timescale 1ns / 1ps

module mewb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mewb_pkg::job_t job_i,
  input  logic           empty_i,
  output logic           pop_o,
  mewb_out_if.source     out_o
);
  import mewb_pkg::*;

  typedef enum logic [6:0] {
    ST_START  = 7'b0000001,
    ST_PREFIX = 7'b0000010,
    ST_C0     = 7'b0000100,
    ST_C1     = 7'b0001000,
    ST_PAD    = 7'b0010000,
    ST_QM     = 7'b0100000,
    ST_EQ     = 7'b1000000
  } step_e;

  step_e              st_q, st_d, cur;
  logic [PfxIdxW-1:0] cnt_q, cnt_d, cur_cnt;
  logic               oval_q;
  logic [CharW-1:0]   char_q, ch;
  logic               last_q, done_q, last, done;
  logic               adv, fire;

  assign adv   = !oval_q || out_o.ready;
  assign fire  = adv && !empty_i;
  assign pop_o = fire && last;

  always_comb begin
    if (st_q == ST_START) begin
      cur_cnt = '0;
      if (job_i.prefix) begin
        cur = ST_PREFIX;
      end else if (job_i.c0_vld) begin
        cur = ST_C0;
      end else begin
        cur = ST_QM;
      end
    end else begin
      cur     = st_q;
      cur_cnt = cnt_q;
    end
  end

  always_comb begin
    ch    = ChQm;
    last  = 1'b0;
    done  = 1'b0;
    st_d  = cur;
    cnt_d = '0;
    case (cur)
      ST_PREFIX: begin
        ch = prefix_char(cur_cnt);
        if (cur_cnt == PfxLastIdx) begin
          st_d = job_i.c0_vld ? ST_C0 : ST_QM;
        end else begin
          cnt_d = cur_cnt + 1'b1;
        end
      end
      ST_C0: begin
        ch = sextet_char(job_i.s0);
        if (job_i.c1_vld) begin
          st_d = ST_C1;
        end else if (job_i.pad != 2'd0) begin
          st_d = ST_PAD;
        end else if (job_i.term) begin
          st_d = ST_QM;
        end else begin
          last = 1'b1;
        end
      end
      ST_C1: begin
        ch   = sextet_char(job_i.s1);
        last = 1'b1;
      end
      ST_PAD: begin
        ch = ChEq;
        if (cur_cnt[1:0] + 2'd1 == job_i.pad) begin
          st_d = ST_QM;
        end else begin
          cnt_d = cur_cnt + 1'b1;
        end
      end
      ST_QM: begin
        ch   = ChQm;
        st_d = ST_EQ;
      end
      ST_EQ: begin
        ch   = ChEq;
        last = 1'b1;
        done = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
    if (last) begin
      st_d = ST_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_START;
      cnt_q  <= '0;
      oval_q <= 1'b0;
    end else if (adv) begin
      oval_q <= fire;
      if (fire) begin
        st_q  <= st_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      char_q <= ch;
      last_q <= last;
      done_q <= done;
    end
  end

  assign out_o.valid       = oval_q;
  assign out_o.out_char    = char_q;
  assign out_o.last_of_run = last_q;
  assign out_o.word_done   = done_q;

endmodule

>>> rtl/core/mime_encoded_word_base64_core.sv
// top level of the base64 encoded word encoder
// channel | dir | beat                              | accepted when
// in_i    | in  | data_byte, terminator             | valid && ready
// out_o   | out | out_char, last_of_run, word_done  | valid && ready
// a source beat is taken every cycle while the job queue has room.
// the back end emits one character per cycle while the output is not stalled and the
// queue is not empty; the rate is set by the single output character port.
// a beat's job is registered in the queue, then its characters in the output register.
// reset clears phase, leftover bits, prefix flag, queue count, step state and output valid.
// output stalls hold the character register and back up through the queue.
`timescale 1ns / 1ps

module mime_encoded_word_base64_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  mewb_in_if.sink    in_i,
  mewb_out_if.source out_o
);
  import mewb_pkg::*;

  job_t push_job, head_job;
  logic push, pop, full, empty;

  mewb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  mewb_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (head_job),
    .full_o  (full),
    .empty_o (empty)
  );

  mewb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (head_job),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> rtl/core/mewb_checker.sv
// port-level checks on the encoded character stream, bound to the top level
`timescale 1ns / 1ps
`include "mime_encoded_word_base64_core_macros.svh"

module mewb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] out_char_i,
  input logic       last_of_run_i,
  input logic       word_done_i
);
  import mewb_pkg::*;

  logic       out_beat;
  logic       out_stall;
  logic       data_end;
  logic [8:0] out_bits;

  assign out_beat  = out_valid_i && out_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign data_end  = out_beat && last_of_run_i && !word_done_i;
  assign out_bits  = {out_char_i, last_of_run_i, word_done_i};

  // a stalled character holds
  `MEWB_ASSERT_NEXT(a_stall_hold, out_stall, out_valid_i && $stable(out_bits))

  // closing character is '=' and ends the run
  `MEWB_ASSERT_NOW(a_done_is_eq, out_valid_i && word_done_i, last_of_run_i && out_char_i == ChEq)

  // a data run ends on a base64 character, never on padding
  `MEWB_ASSERT_NOW(a_data_end, data_end, out_char_i != ChEq && out_char_i != ChQm)

endmodule

bind mime_encoded_word_base64_core mewb_checker u_mewb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_char_i    (out_o.out_char),
  .last_of_run_i (out_o.last_of_run),
  .word_done_i   (out_o.word_done)
);

>>> sim/tb_mime_encoded_word_base64_core.sv
// self-checking testbench of the base64 encoded word encoder with random stalls on both channels
`timescale 1ns / 1ps

module tb_mime_encoded_word_base64_core;
  import mewb_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandomBeats = 300;
  localparam logic [8*16-1:0] WordPrefix = "=?ISO-2022-JP?B?";

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             terminator;
  } src_beat_t;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
    logic             done;
  } enc_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mewb_in_if  byte_bus ();
  mewb_out_if char_bus ();

  mime_encoded_word_base64_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_bus),
    .out_o  (char_bus)
  );

  always #6 clk = ~clk;

  src_beat_t pending_beats[$];
  enc_char_t expected_chars[$];

  // encoder state as predicted
  logic [1:0] enc_phase = 2'd0;
  logic [3:0] enc_left = 4'd0;
  logic       enc_prefix_out = 1'b0;

  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned src_count = 0;
  int unsigned snk_count = 0;
  int unsigned src_gap = 0;
  int unsigned snk_wait = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  src_beat_t   drv_beat;

  function automatic logic [CharW-1:0] base64_symbol(input logic [5:0] v);
    if (v < 6'd26) return 7'h41 + {1'b0, v};
    if (v < 6'd52) return 7'h61 + {1'b0, v} - 7'd26;
    if (v < 6'd62) return 7'h30 + {1'b0, v} - 7'd52;
    if (v == 6'd62) return 7'h2B;
    return 7'h2F;
  endfunction

  function automatic enc_char_t mk_char(input logic [CharW-1:0] ch, input logic done);
    enc_char_t c;
    c.ch = ch;
    c.last = 1'b0;
    c.done = done;
    return c;
  endfunction

  task automatic encode_beat(input src_beat_t b);
    enc_char_t run[18];
    int n;
    int i;
    n = 0;
    if (!enc_prefix_out) begin
      for (i = 0; i < 16; i++) begin
        run[n] = mk_char(WordPrefix[8*(15-i) +: 7], 1'b0);
        n++;
      end
      enc_prefix_out = 1'b1;
    end
    if (b.terminator) begin
      case (enc_phase)
        2'd1: begin
          run[n] = mk_char(base64_symbol({enc_left[1:0], 4'b0}), 1'b0);
          run[n+1] = mk_char(ChEq, 1'b0);
          run[n+2] = mk_char(ChEq, 1'b0);
          n += 3;
        end
        2'd2: begin
          run[n] = mk_char(base64_symbol({enc_left, 2'b0}), 1'b0);
          run[n+1] = mk_char(ChEq, 1'b0);
          n += 2;
        end
        default: ;
      endcase
      run[n] = mk_char(ChQm, 1'b0);
      run[n+1] = mk_char(ChEq, 1'b1);
      n += 2;
      enc_phase = 2'd0;
      enc_left = 4'd0;
      enc_prefix_out = 1'b0;
    end else begin
      case (enc_phase)
        2'd1: begin
          run[n] = mk_char(base64_symbol({enc_left[1:0], b.data_byte[7:4]}), 1'b0);
          n++;
          enc_left = b.data_byte[3:0];
          enc_phase = 2'd2;
        end
        2'd2: begin
          run[n] = mk_char(base64_symbol({enc_left, b.data_byte[7:6]}), 1'b0);
          run[n+1] = mk_char(base64_symbol(b.data_byte[5:0]), 1'b0);
          n += 2;
          enc_left = 4'd0;
          enc_phase = 2'd0;
        end
        default: begin
          run[n] = mk_char(base64_symbol(b.data_byte[7:2]), 1'b0);
          n++;
          enc_left = {2'b0, b.data_byte[1:0]};
          enc_phase = 2'd1;
        end
      endcase
    end
    run[n-1].last = 1'b1;
    for (i = 0; i < n; i++) expected_chars.push_back(run[i]);
  endtask

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("mismatch %s: expected 0x%0h got 0x%0h at %0t", what, exp_v, got_v, $time);
    errors++;
  endtask

  task automatic add_beat(input logic [ByteW-1:0] b, input logic term);
    src_beat_t s;
    s.data_byte = b;
    s.terminator = term;
    pending_beats.push_back(s);
  endtask

  // source driver
  always @(negedge clk) begin
    if (rst_n && (!byte_bus.valid || in_taken)) begin
      if (src_gap > 0) begin
        byte_bus.valid <= 1'b0;
        src_gap--;
      end else if (pending_beats.size() > 0) begin
        drv_beat = pending_beats.pop_front();
        byte_bus.valid <= 1'b1;
        byte_bus.data_byte <= drv_beat.data_byte;
        byte_bus.terminator <= drv_beat.terminator;
        src_count++;
        src_gap = ((src_count / 48) % 3 == 2) ? 0 : $urandom_range(0, 6);
      end else begin
        byte_bus.valid <= 1'b0;
      end
    end
  end

  // sink driver, with one long hold-off to back up the block
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        snk_count++;
        snk_wait = ((snk_count / 64) % 3 == 1) ? 0 : $urandom_range(0, 6);
        if (!hold_done && snk_count == 150) begin
          hold_left = 400;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        char_bus.ready <= 1'b0;
        hold_left--;
      end else if (snk_wait > 0) begin
        char_bus.ready <= 1'b0;
        snk_wait--;
      end else begin
        char_bus.ready <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    enc_char_t e;
    in_taken <= byte_bus.valid && byte_bus.ready;
    out_taken <= char_bus.valid && char_bus.ready;
    if (rst_n) begin
      if (char_bus.valid && char_bus.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected beat", 32'd0, 32'(char_bus.out_char));
        end else begin
          e = expected_chars.pop_front();
          if (char_bus.out_char !== e.ch)
            report_mismatch("out_char", 32'(e.ch), 32'(char_bus.out_char));
          if (char_bus.last_of_run !== e.last)
            report_mismatch("last_of_run", 32'(e.last), 32'(char_bus.last_of_run));
          if (char_bus.word_done !== e.done)
            report_mismatch("word_done", 32'(e.done), 32'(char_bus.word_done));
        end
      end
      if (byte_bus.valid && byte_bus.ready)
        encode_beat('{byte_bus.data_byte, byte_bus.terminator});
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((byte_bus.valid && byte_bus.ready) || (char_bus.valid && char_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("mime_encoded_word_base64_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned cnt;
    int unsigned len;
    int unsigned k;
    byte_bus.valid = 1'b0;
    byte_bus.data_byte = '0;
    byte_bus.terminator = 1'b0;
    char_bus.ready = 1'b0;

    // empty word, then a terminator carrying a stray byte
    add_beat(8'h00, 1'b1);
    add_beat(8'hFF, 1'b1);
    // flush at phase one and phase two
    add_beat(8'h00, 1'b0);
    add_beat(8'h00, 1'b1);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hA5, 1'b1);
    // full groups covering every symbol class
    add_beat(8'hF8, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h0F, 1'b0);
    add_beat(8'hBE, 1'b0);
    add_beat(8'h69, 1'b0);
    add_beat(8'hD7, 1'b0);
    add_beat(8'h5D, 1'b0);
    add_beat(8'h55, 1'b1);
    add_beat(8'h80, 1'b0);
    add_beat(8'h7F, 1'b0);
    add_beat(8'h01, 1'b0);
    add_beat(8'hFE, 1'b1);

    cnt = 0;
    while (cnt < RandomBeats) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      for (k = 0; k < len; k++) add_beat(8'($urandom_range(0, 255)), 1'b0);
      add_beat(8'($urandom_range(0, 255)), 1'b1);
      cnt += len + 1;
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || byte_bus.valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0 && expected_chars.size() == 0) begin
      $display("mime_encoded_word_base64_core test passed");
    end else begin
      $display("mime_encoded_word_base64_core test failed");
    end
    $finish;
  end

endmodule
